// ----- design/kdaf_pkg.sv -----
// shared types, constants and key decode for the keypad debounce/auto-repeat block
`default_nettype none
package kdaf_pkg;

    localparam int QDEPTH = 32;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [1:0] FN_SCAN  = 2'd0;
    localparam logic [1:0] FN_POP   = 2'd1;
    localparam logic [1:0] FN_FLUSH = 2'd2;

    localparam logic [1:0] CFG_RPT_START = 2'd0;
    localparam logic [1:0] CFG_RPT_IVL   = 2'd1;
    localparam logic [1:0] CFG_PERIOD    = 2'd2;

    localparam logic [7:0] RST_RPT_START = 8'd10;
    localparam logic [7:0] RST_RPT_IVL   = 8'd2;
    localparam logic [9:0] RST_PERIOD    = 10'd50;

    localparam logic [7:0] NO_CODE   = 8'hFF;
    localparam logic [3:0] CODE_NONE = 4'd0;
    localparam logic [3:0] CODE_KEY9 = 4'd9;

    typedef enum logic [1:0] {
        ST_UP        = 2'd0,
        ST_DEBOUNCE  = 2'd1,
        ST_RPT_START = 2'd2,
        ST_RPT       = 2'd3
    } scan_state_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       flush;
        logic [3:0] code;
    } q_cmd_t;

    typedef struct packed {
        logic [QCW-1:0] count_next;
        logic           pop_ok;
    } q_stat_t;

    // exactly one pressed key gives its code, anything else gives none
    function automatic logic [3:0] decode_keys(input logic [7:0] lines, input logic ninth);
        logic [3:0] code;
        code = CODE_NONE;
        if (!ninth)
        begin
            if (lines == 8'hFF)
            begin
                code = CODE_KEY9;
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (lines == 8'(~(8'd1 << i)))
                begin
                    code = 4'(i + 1);
                end
            end
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- design/kdaf_queue.sv -----
// key-code fifo: synchronous memory with read/write pointers and fill count
`default_nettype none
module kdaf_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kdaf_pkg::q_cmd_t cmd,
    output kdaf_pkg::q_stat_t     stat,
    output logic [3:0]            rd_code
);
    import kdaf_pkg::*;

    logic [3:0]     mem [QDEPTH];
    logic [3:0]     rd_code_reg;
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           push_ok;
    logic           pop_ok;

    assign push_ok = cmd.push && (count_reg != QCW'(QDEPTH));
    assign pop_ok  = cmd.pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        else if (cmd.flush)
        begin
            rd_ptr_next = wr_ptr_reg;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // one item per cycle, so a read never hits an entry written at the same edge
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= cmd.code;
        end
        if (pop_ok)
        begin
            rd_code_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_code         = rd_code_reg;
    assign stat.count_next = count_next;
    assign stat.pop_ok     = pop_ok;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted push did not grow count");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush && !cmd.push && !cmd.pop) |=> (count_reg == '0) && (rd_ptr_reg == wr_ptr_reg))
        else $error("flush left codes behind");

    a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && !cmd.push && count_reg == '0) |=> $stable(rd_ptr_reg) && count_reg == '0)
        else $error("pop on empty queue moved state");
`endif
endmodule
`default_nettype wire

// ----- design/keypad_debounce_autorepeat_fifo_top.sv -----
// top level: key decode, debounce/auto-repeat state machine, fifo and result stages
// Keypad scanner with debounce, auto-repeat and a 32-deep key-code fifo.
// Input channel (in_valid/in_ready) carries one beat per command: func 0 is a
// scan tick with the key lines, func 1 pops the oldest code, func 2 flushes
// the queue, func 3 does nothing. Every input beat yields exactly one output
// beat (out_valid/out_ready) with the popped code (255 if none), the queue
// status after the command and held_time_ms = held ticks * scan period.
// From input beat to output beat: the accept edge updates the state machine
// and the fifo and reads the fifo memory; the result stage, when it advances,
// forms the result and the held-time product into the output register.
// Throughput is one beat per cycle while the output side does not stall.
// Two result slots sit between the sides, so one more beat is taken while the
// output is stalled; in_ready drops only when both slots are full.
// Reset (rst_n, asynchronous) returns the machine to the up state, clears the
// counters and the fifo pointers and loads the register defaults; the fifo
// memory needs no clearing. Configuration writes (cfg_we, cfg_addr,
// cfg_wdata) take effect at once and are expected only while idle.
`default_nettype none
module keypad_debounce_autorepeat_fifo_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [9:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  key_lines,
    input  wire logic        ninth_key_line,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       popped_code,
    output logic             key_available,
    output logic [5:0]       queued_count,
    output logic [25:0]      held_time_ms
);
    import kdaf_pkg::*;

    logic [7:0]  rpt_start_reg;
    logic [7:0]  rpt_ivl_reg;
    logic [9:0]  period_reg;

    scan_state_t state_reg;
    scan_state_t state_next;
    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic [7:0]  frc_reg;
    logic [7:0]  frc_next;
    logic [7:0]  rc_reg;
    logic [7:0]  rc_next;

    logic        in_fire;
    logic        scan_fire;
    logic [3:0]  code;
    logic        down;
    logic        push;
    q_cmd_t      q_cmd;
    q_stat_t     q_stat;
    logic [3:0]  q_rd_code;

    logic        p_valid_reg;
    logic        p_pop_ok_reg;
    logic [5:0]  p_count_reg;
    logic [15:0] p_held_reg;
    logic        p_adv;

    logic        out_valid_reg;
    logic [7:0]  out_code_reg;
    logic        out_avail_reg;
    logic [5:0]  out_count_reg;
    logic [25:0] out_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_start_reg <= RST_RPT_START;
            rpt_ivl_reg   <= RST_RPT_IVL;
            period_reg    <= RST_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_RPT_START: rpt_start_reg <= cfg_wdata[7:0];
                CFG_RPT_IVL:   rpt_ivl_reg   <= cfg_wdata[7:0];
                CFG_PERIOD:    period_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    assign p_adv     = p_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !p_valid_reg || p_adv;
    assign in_fire   = in_valid && in_ready;
    assign scan_fire = in_fire && (func == FN_SCAN);
    assign code      = decode_keys(key_lines, ninth_key_line);
    assign down      = (code != CODE_NONE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (scan_fire)
        begin
            unique case (state_reg)
                ST_UP:
                begin
                    if (down)
                    begin
                        state_next = ST_DEBOUNCE;
                    end
                end
                ST_DEBOUNCE:
                begin
                    state_next = down ? ST_RPT_START : ST_UP;
                end
                ST_RPT_START:
                begin
                    if (!down)
                    begin
                        state_next = ST_DEBOUNCE;
                    end
                    else if (frc_reg == 8'd1)
                    begin
                        state_next = ST_RPT;
                    end
                end
                ST_RPT:
                begin
                    if (!down)
                    begin
                        state_next = ST_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    // counters and enqueue
    always_comb
    begin
        held_next = held_reg;
        frc_next  = frc_reg;
        rc_next   = rc_reg;
        push      = 1'b0;
        if (scan_fire)
        begin
            if (down)
            begin
                held_next = held_reg + 16'd1;
            end
            unique case (state_reg)
                ST_UP:
                begin
                    if (down)
                    begin
                        held_next = '0;
                    end
                end
                ST_DEBOUNCE:
                begin
                    if (down)
                    begin
                        push     = 1'b1;
                        frc_next = rpt_start_reg;
                    end
                end
                ST_RPT_START:
                begin
                    if (down && frc_reg != '0)
                    begin
                        frc_next = frc_reg - 8'd1;
                        if (frc_reg == 8'd1)
                        begin
                            push    = 1'b1;
                            rc_next = rpt_ivl_reg;
                        end
                    end
                end
                ST_RPT:
                begin
                    if (down && rc_reg != '0)
                    begin
                        rc_next = rc_reg - 8'd1;
                        if (rc_reg == 8'd1)
                        begin
                            push    = 1'b1;
                            rc_next = rpt_ivl_reg;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_UP;
            held_reg  <= '0;
            frc_reg   <= '0;
            rc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            frc_reg   <= frc_next;
            rc_reg    <= rc_next;
        end
    end

    assign q_cmd.push  = push;
    assign q_cmd.pop   = in_fire && (func == FN_POP);
    assign q_cmd.flush = in_fire && (func == FN_FLUSH);
    assign q_cmd.code  = code;

    kdaf_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_cmd),
        .stat    (q_stat),
        .rd_code (q_rd_code)
    );

    // result stage: status after the item, popped data lands in the fifo read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            p_valid_reg <= 1'b1;
        end
        else if (p_adv)
        begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p_pop_ok_reg <= q_stat.pop_ok;
            p_count_reg  <= 6'(q_stat.count_next);
            p_held_reg   <= held_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (p_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            out_code_reg  <= p_pop_ok_reg ? {4'd0, q_rd_code} : NO_CODE;
            out_avail_reg <= (p_count_reg != '0);
            out_count_reg <= p_count_reg;
            out_time_reg  <= 26'(p_held_reg) * 26'(period_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign popped_code   = out_code_reg;
    assign key_available = out_avail_reg;
    assign queued_count  = out_count_reg;
    assign held_time_ms  = out_time_reg;

endmodule
`default_nettype wire

// ----- tb/sv/keypad_fifo_checker.sv -----
// keypad command predictor and result scoreboard for the keypad debounce/auto-repeat block
module keypad_fifo_checker import kdaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  key_lines,
    input  logic        ninth_key_line,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  popped_code,
    input  logic        key_available,
    input  logic [5:0]  queued_count,
    input  logic [25:0] held_time_ms,
    output int          pending,
    output int          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  code;
        logic        avail;
        logic [5:0]  count;
        logic [25:0] held_ms;
    } key_report_t;

    logic [7:0]     start_delay_r;
    logic [7:0]     interval_r;
    logic [9:0]     period_r;
    scan_state_t    st;
    logic [15:0]    held;
    logic [7:0]     first_cd;
    logic [7:0]     rpt_cd;
    logic [3:0]     codes [QDEPTH];
    logic [QAW-1:0] wr_ptr;
    logic [QAW-1:0] rd_ptr;
    logic [QCW-1:0] n_codes;
    key_report_t    reports_due [$];
    key_report_t    want;

    initial
    begin
        pending = 0;
        mismatches = 0;
    end

    function automatic logic [3:0] key_code(input logic [7:0] lines, input logic ninth);
        logic [3:0] c;
        int         n;
        c = CODE_NONE;
        n = 0;
        if (!ninth)
        begin
            if (lines == 8'hFF)
                c = CODE_KEY9;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (!lines[i])
                begin
                    n++;
                    c = 4'(i + 1);
                end
            end
            if (n != 1)
                c = CODE_NONE;
        end
        return c;
    endfunction

    task automatic push_code(input logic [3:0] c);
        if (n_codes < QDEPTH)
        begin
            codes[wr_ptr] = c;
            wr_ptr = wr_ptr + 1'b1;
            n_codes = n_codes + 1'b1;
        end
    endtask

    task automatic scan_tick(input logic [7:0] lines, input logic ninth);
        logic [3:0] c;
        logic       down;
        c = key_code(lines, ninth);
        down = (c != CODE_NONE);
        if (down)
            held = held + 16'd1;
        case (st)
            ST_UP:
            begin
                if (down)
                begin
                    st = ST_DEBOUNCE;
                    held = '0;
                end
            end
            ST_DEBOUNCE:
            begin
                if (down)
                begin
                    push_code(c);
                    first_cd = start_delay_r;
                    st = ST_RPT_START;
                end
                else
                    st = ST_UP;
            end
            ST_RPT_START:
            begin
                if (!down)
                    st = ST_DEBOUNCE;
                else if (first_cd != 0)
                begin
                    first_cd = first_cd - 8'd1;
                    if (first_cd == 0)
                    begin
                        push_code(c);
                        rpt_cd = interval_r;
                        st = ST_RPT;
                    end
                end
            end
            default:
            begin
                if (!down)
                    st = ST_DEBOUNCE;
                else if (rpt_cd != 0)
                begin
                    rpt_cd = rpt_cd - 8'd1;
                    if (rpt_cd == 0)
                    begin
                        push_code(c);
                        rpt_cd = interval_r;
                    end
                end
            end
        endcase
    endtask

    task automatic apply_command(input logic [1:0] f, input logic [7:0] lines,
                                 input logic ninth);
        key_report_t r;
        r.code = NO_CODE;
        case (f)
            FN_SCAN:
                scan_tick(lines, ninth);
            FN_POP:
            begin
                if (n_codes != 0)
                begin
                    r.code = {4'd0, codes[rd_ptr]};
                    rd_ptr = rd_ptr + 1'b1;
                    n_codes = n_codes - 1'b1;
                end
            end
            FN_FLUSH:
            begin
                rd_ptr = wr_ptr;
                n_codes = '0;
            end
            default:
                ;
        endcase
        r.avail = (n_codes != 0);
        r.count = 6'(n_codes);
        r.held_ms = {10'd0, held} * {16'd0, period_r};
        reports_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [25:0] exp_v,
                               input logic [25:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_r = RST_RPT_START;
            interval_r = RST_RPT_IVL;
            period_r = RST_PERIOD;
            st = ST_UP;
            held = '0;
            first_cd = '0;
            rpt_cd = '0;
            wr_ptr = '0;
            rd_ptr = '0;
            n_codes = '0;
            reports_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RPT_START: start_delay_r = cfg_wdata[7:0];
                    CFG_RPT_IVL:   interval_r = cfg_wdata[7:0];
                    CFG_PERIOD:    period_r = cfg_wdata;
                    default:       ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("result beat with no command waiting");
                    mismatches++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("popped_code", 26'(want.code), 26'(popped_code));
                    check_field("key_available", 26'(want.avail), 26'(key_available));
                    check_field("queued_count", 26'(want.count), 26'(queued_count));
                    check_field("held_time_ms", want.held_ms, held_time_ms);
                end
            end
            if (in_valid && in_ready)
                apply_command(func, key_lines, ninth_key_line);
        end
        pending = reports_due.size();
    end

endmodule

// ----- tb/sv/keypad_debounce_autorepeat_fifo_top_tb.sv -----
// testbench top: keypad command and register stimulus, result-side stalls and verdict
module keypad_debounce_autorepeat_fifo_top_tb import kdaf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FN_NOP   = 2'd3;
    localparam logic [1:0] CFG_NONE = 2'd3;
    localparam logic [7:0] LINES_UP = 8'hFF;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [9:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  key_lines;
    logic        ninth_key_line;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  popped_code;
    logic        key_available;
    logic [5:0]  queued_count;
    logic [25:0] held_time_ms;
    int          pending;
    int          mismatches;

    int          beats_sent;
    int          rx_wait;
    bit          tx_idle_on;
    bit          rx_stall_on;

    keypad_debounce_autorepeat_fifo_top DUT (.*);

    keypad_fifo_checker u_checker (.*);

    always #5ns clk = ~clk;

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // result side: a random stall, when enabled, before each result beat
    initial
    begin
        out_ready = 1'b0;
        rx_wait = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= (rx_wait == 0);
            if (rx_wait != 0)
                rx_wait--;
            @(posedge clk);
            if (out_valid && out_ready)
                rx_wait = rx_stall_on ? $urandom_range(0, 15) : 0;
        end
    end

    task automatic send_beat(input logic [1:0] f, input logic [7:0] lines, input logic ninth);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key_lines <= lines;
        ninth_key_line <= ninth;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (f != FN_NOP)
            beats_sent++;
    endtask

    task automatic press_tick(input logic [3:0] code);
        if (code == CODE_KEY9)
            send_beat(FN_SCAN, LINES_UP, 1'b0);
        else
            send_beat(FN_SCAN, ~(8'd1 << (code - 1)), 1'b1);
    endtask

    // hold one key for a number of scan ticks with some contact bounce, then release
    task automatic hold_key(input logic [3:0] code, input int ticks, input int bounce_pct);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 99) < bounce_pct)
                send_beat(FN_SCAN, 8'($urandom), 1'($urandom));
            else
                press_tick(code);
        end
        send_beat(FN_SCAN, LINES_UP, 1'b1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] start_delay, input logic [7:0] interval,
                              input logic [9:0] period);
        write_reg(CFG_RPT_START, {2'b00, start_delay});
        write_reg(CFG_RPT_IVL, {2'b00, interval});
        write_reg(CFG_PERIOD, period);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_traffic(input int count);
        int goal;
        int pick;
        int n;
        goal = beats_sent + count;
        while (beats_sent < goal)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                n = $urandom_range(0, 19);
                if (n < 14)
                    n = $urandom_range(1, 12);
                else if (n < 18)
                    n = $urandom_range(13, 40);
                else
                    n = $urandom_range(41, 300);
                hold_key(4'($urandom_range(1, 9)), n, 8);
            end
            else if (pick < 82)
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                repeat (n) send_beat(FN_POP, 8'($urandom), 1'($urandom));
            end
            else if (pick < 86)
                send_beat(FN_FLUSH, 8'($urandom), 1'($urandom));
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_beat(2'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_RPT_START;
        cfg_wdata = '0;
        in_valid = 1'b0;
        func = FN_SCAN;
        key_lines = LINES_UP;
        ninth_key_line = 1'b1;
        beats_sent = 0;
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty queue, every key, release during the repeat start delay, multi-key patterns
        send_beat(FN_POP, 8'h00, 1'b0);
        send_beat(FN_NOP, 8'h5A, 1'b1);
        send_beat(FN_FLUSH, LINES_UP, 1'b1);
        press_tick(4'd1);
        press_tick(4'd1);
        for (int k = 2; k <= 9; k++)
        begin
            send_beat(FN_SCAN, LINES_UP, 1'b1);
            press_tick(4'(k));
        end
        send_beat(FN_SCAN, 8'hFC, 1'b1);
        send_beat(FN_SCAN, 8'h00, 1'b0);
        send_beat(FN_SCAN, 8'hFE, 1'b0);
        send_beat(FN_SCAN, LINES_UP, 1'b1);
        send_beat(FN_POP, LINES_UP, 1'b1);
        send_beat(FN_POP, LINES_UP, 1'b1);
        send_beat(FN_FLUSH, 8'h00, 1'b0);
        send_beat(FN_POP, LINES_UP, 1'b1);
        drain();

        set_config(8'd0, 8'd0, 10'd1000);
        run_traffic(110);
        drain();

        // long hold: a repeat on every tick fills the queue and drops codes
        set_config(8'd1, 8'd1, 10'd1000);
        tx_idle_on = 1'b0;
        rx_stall_on = 1'b0;
        hold_key(4'd5, 40, 0);
        run_traffic(110);
        drain();

        set_config(8'd2, 8'd0, 10'd1);
        run_traffic(110);
        drain();

        set_config(8'd255, 8'd255, 10'd1023);
        run_traffic(110);
        drain();

        set_config(8'd4, 8'd3, 10'd7);
        write_reg(CFG_RPT_START, 10'h303);
        write_reg(CFG_NONE, 10'h3FF);
        run_traffic(110);
        drain();

        repeat (2)
        begin
            set_config(8'($urandom_range(0, 8)), 8'($urandom_range(0, 4)),
                       10'($urandom_range(1, 1000)));
            run_traffic(110);
            drain();
        end

        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/kdaf_pkg.sv
design/kdaf_queue.sv
design/keypad_debounce_autorepeat_fifo_top.sv
tb/sv/keypad_fifo_checker.sv
tb/sv/keypad_debounce_autorepeat_fifo_top_tb.sv
